// ----- hdl/ptc_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ptc_pkg
// Shared types and constants for the pressure/temperature compensation block.
// ----------------------------------------------------------------------------
package ptc_pkg;

   localparam int RawWidth  = 20;
   localparam int TempWidth = 16;
   localparam int PresWidth = 32;
   localparam int CsrWidth  = 64;
   localparam int CsrIdxWidth = 2;

   localparam logic [CsrIdxWidth-1:0] CSR_TEMP_COEF = 2'd0;
   localparam logic [CsrIdxWidth-1:0] CSR_PRES_LOW  = 2'd1;
   localparam logic [CsrIdxWidth-1:0] CSR_PRES_HIGH = 2'd2;
   localparam logic [CsrIdxWidth-1:0] CSR_PRES_NINE = 2'd3;

   localparam logic signed [63:0] FineOffset = 64'sd128000;
   localparam logic signed [63:0] PresScale  = 64'sd3125;
   localparam logic [63:0]        PresFull   = 64'd1048576;
   localparam int P4Shift = 35;
   localparam int P1Shift = 33;
   localparam logic signed [31:0] RoundHalf = 32'sd128;

   // Number of quotient bits resolved per divider stage
   localparam int DivBitsPerStage = 2;
   localparam int DivStages = 64 / DivBitsPerStage;

   typedef struct packed {
      logic [RawWidth-1:0] raw_temperature;
      logic [RawWidth-1:0] raw_pressure;
   } req_type;

   typedef struct packed {
      logic signed [TempWidth-1:0] temperature_centi;
      logic [PresWidth-1:0]        pressure_q24_8;
      logic                        divide_fault;
   } rsp_type;

   typedef struct packed {
      logic [15:0]        t1;
      logic signed [15:0] t2;
      logic signed [15:0] t3;
      logic [15:0]        p1;
      logic signed [15:0] p2;
      logic signed [15:0] p3;
      logic signed [15:0] p4;
      logic signed [15:0] p5;
      logic signed [15:0] p6;
      logic signed [15:0] p7;
      logic signed [15:0] p8;
      logic signed [15:0] p9;
   } coef_type;

   // Payload that rides along through the divider stages
   typedef struct packed {
      logic signed [TempWidth-1:0] temp;
      logic signed [15:0]          p7;
      logic signed [15:0]          p8;
      logic signed [15:0]          p9;
      logic                        neg;
      logic                        fault;
   } div_side_type;

endpackage

// ----- hdl/ptc_stream_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ptc_stream_if
// Valid/ready channel carrying one payload struct.
// ----------------------------------------------------------------------------
interface ptc_stream_if #(parameter type payload_type = logic) ();
   logic        valid;
   logic        ready;
   payload_type data;

   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

// ----- hdl/ptc_div_stage.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ptc_div_stage
// One registered stage of the restoring unsigned 64/64 divider.
// ----------------------------------------------------------------------------
module ptc_div_stage (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       advance,
   input  logic                       valid_in,
   input  logic [63:0]                rem_in,
   input  logic [63:0]                quo_in,
   input  logic [63:0]                den_in,
   input  ptc_pkg::div_side_type      side_in,
   output logic                       valid_out,
   output logic [63:0]                rem_out,
   output logic [63:0]                quo_out,
   output logic [63:0]                den_out,
   output ptc_pkg::div_side_type      side_out
);
   logic                  valid_ff;
   logic [63:0]           rem_ff, quo_ff, den_ff;
   ptc_pkg::div_side_type side_ff;
   logic [63:0]           rem_in_c, quo_in_c;

   // Shift one dividend bit into the partial remainder per step
   always_comb begin
      logic [64:0] shifted;
      logic [64:0] trial;
      logic [63:0] r, q;
      r = rem_in;
      q = quo_in;
      for (int k = 0; k < ptc_pkg::DivBitsPerStage; k++) begin
         shifted = {r, q[63]};
         trial   = shifted - {1'b0, den_in};
         q = {q[62:0], 1'b0};
         if (!trial[64] || r[63]) begin
            r = trial[63:0];
            q[0] = 1'b1;
         end else begin
            r = shifted[63:0];
         end
      end
      rem_in_c = r;
      quo_in_c = q;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (advance) begin
         valid_ff <= valid_in;
      end
      if (advance) begin
         rem_ff  <= rem_in_c;
         quo_ff  <= quo_in_c;
         den_ff  <= den_in;
         side_ff <= side_in;
      end
   end

   assign valid_out = valid_ff;
   assign rem_out   = rem_ff;
   assign quo_out   = quo_ff;
   assign den_out   = den_ff;
   assign side_out  = side_ff;
endmodule

// ----- hdl/pressure_temperature_compensation.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pressure_temperature_compensation
// Pipelined integer compensation of raw barometric temperature and pressure.
// ----------------------------------------------------------------------------
// Accepts one raw temperature/pressure pair per cycle and returns one result
// per pair, in order. A sample passes 9 front stages, 32 divider stages, 4
// back-end stages and one output stage; throughput is one transfer per cycle
// whenever the response side is ready. The whole pipeline holds when the
// output register is full and not taken, so nothing is lost or repeated. The
// long division is a chain of 32 registered stages resolving two quotient
// bits each; every other stage does at most a short multiply-add, and the
// full 64-bit product in the pressure correction is split into 32-bit partial
// products over two stages. The user must write coefficients through the csr
// port only while the block is idle; the block itself does not enforce this.
module pressure_temperature_compensation (
   input  logic                                  clock,
   input  logic                                  reset,
   ptc_stream_if.sink                            req,
   ptc_stream_if.source                          rsp,
   input  logic                                  csr_write,
   input  logic [ptc_pkg::CsrIdxWidth-1:0]       csr_index,
   input  logic [ptc_pkg::CsrWidth-1:0]          csr_data
);
   // ---------------------------------------------------------------- csr
   logic [47:0] tcoef_ff;
   logic [63:0] plow_ff, phigh_ff;
   logic [15:0] pnine_ff;
   ptc_pkg::coef_type coef;

   always_ff @(posedge clock) begin
      if (reset) begin
         tcoef_ff <= '0;
         plow_ff  <= '0;
         phigh_ff <= '0;
         pnine_ff <= '0;
      end else if (csr_write) begin
         unique case (csr_index)
            ptc_pkg::CSR_TEMP_COEF: tcoef_ff <= csr_data[47:0];
            ptc_pkg::CSR_PRES_LOW:  plow_ff  <= csr_data;
            ptc_pkg::CSR_PRES_HIGH: phigh_ff <= csr_data;
            ptc_pkg::CSR_PRES_NINE: pnine_ff <= csr_data[15:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      coef.t1 = tcoef_ff[15:0];
      coef.t2 = tcoef_ff[31:16];
      coef.t3 = tcoef_ff[47:32];
      coef.p1 = plow_ff[15:0];
      coef.p2 = plow_ff[31:16];
      coef.p3 = plow_ff[47:32];
      coef.p4 = plow_ff[63:48];
      coef.p5 = phigh_ff[15:0];
      coef.p6 = phigh_ff[31:16];
      coef.p7 = phigh_ff[47:32];
      coef.p8 = phigh_ff[63:48];
      coef.p9 = pnine_ff;
   end

   // Global hold: advance only when the output register can take a value
   logic out_valid_ff;
   logic advance;
   assign advance   = !out_valid_ff || rsp.ready;
   assign req.ready = advance;

   // ------------------------------------------------------ stage 1: diffs
   logic        s1_v_ff;
   logic signed [31:0] s1_a_ff, s1_d_ff;
   logic [19:0] s1_adcp_ff;
   always_ff @(posedge clock) begin
      if (reset) s1_v_ff <= 1'b0;
      else if (advance) s1_v_ff <= req.valid;
      if (advance) begin
         s1_a_ff <= 32'({12'd0, req.data.raw_temperature} >> 3)
                    - 32'({16'd0, coef.t1} << 1);
         s1_d_ff <= 32'({12'd0, req.data.raw_temperature} >> 4) - 32'({16'd0, coef.t1});
         s1_adcp_ff <= req.data.raw_pressure;
      end
   end

   // --------------------------------------------------- stage 2: products
   logic        s2_v_ff;
   logic signed [31:0] s2_tv1_ff, s2_dd_ff;
   logic [19:0] s2_adcp_ff;
   always_ff @(posedge clock) begin
      if (reset) s2_v_ff <= 1'b0;
      else if (advance) s2_v_ff <= s1_v_ff;
      if (advance) begin
         s2_tv1_ff  <= (s1_a_ff * 32'(coef.t2)) >>> 11;
         s2_dd_ff   <= (s1_d_ff * s1_d_ff) >>> 12;
         s2_adcp_ff <= s1_adcp_ff;
      end
   end

   // ------------------------------------------------ stage 3: fine temp
   logic        s3_v_ff;
   logic signed [31:0] s3_fine_ff;
   logic [19:0] s3_adcp_ff;
   always_ff @(posedge clock) begin
      if (reset) s3_v_ff <= 1'b0;
      else if (advance) s3_v_ff <= s2_v_ff;
      if (advance) begin
         s3_fine_ff <= s2_tv1_ff + ((s2_dd_ff * 32'(coef.t3)) >>> 14);
         s3_adcp_ff <= s2_adcp_ff;
      end
   end

   // ------------------- stage 4: centidegrees, v1 = fine - 128000
   // v1 always fits in 34 signed bits, which keeps the squares narrow
   logic        s4_v_ff;
   logic signed [15:0] s4_temp_ff;
   logic signed [33:0] s4_v1_ff;
   logic [19:0] s4_adcp_ff;
   logic signed [31:0] tc_c;
   assign tc_c = (s3_fine_ff * 32'sd5 + ptc_pkg::RoundHalf) >>> 8;
   always_ff @(posedge clock) begin
      if (reset) s4_v_ff <= 1'b0;
      else if (advance) s4_v_ff <= s3_v_ff;
      if (advance) begin
         priority if (tc_c > 32'sd32767) s4_temp_ff <= 16'sh7fff;
         else if (tc_c < -32'sd32768)   s4_temp_ff <= 16'sh8000;
         else                           s4_temp_ff <= tc_c[15:0];
         s4_v1_ff   <= 34'(s3_fine_ff) - 34'(ptc_pkg::FineOffset);
         s4_adcp_ff <= s3_adcp_ff;
      end
   end

   // ---------------------------------- stage 5: v1*v1, v1*p5, v1*p2
   logic        s5_v_ff;
   logic signed [15:0] s5_temp_ff;
   logic signed [63:0] s5_sq_ff, s5_v1p5_ff, s5_v1p2_ff;
   logic [19:0] s5_adcp_ff;
   logic signed [67:0] sq_c;
   logic signed [49:0] v1p5_c, v1p2_c;
   assign sq_c   = s4_v1_ff * s4_v1_ff;
   assign v1p5_c = s4_v1_ff * coef.p5;
   assign v1p2_c = s4_v1_ff * coef.p2;
   always_ff @(posedge clock) begin
      if (reset) s5_v_ff <= 1'b0;
      else if (advance) s5_v_ff <= s4_v_ff;
      if (advance) begin
         s5_temp_ff <= s4_temp_ff;
         s5_sq_ff   <= sq_c[63:0];
         s5_v1p5_ff <= 64'(v1p5_c);
         s5_v1p2_ff <= 64'(v1p2_c);
         s5_adcp_ff <= s4_adcp_ff;
      end
   end

   // ---------------------------------- stage 6: sq*p6, sq*p3
   logic        s6_v_ff;
   logic signed [15:0] s6_temp_ff;
   logic signed [63:0] s6_v2_ff, s6_v1_ff;
   logic [19:0] s6_adcp_ff;
   always_ff @(posedge clock) begin
      if (reset) s6_v_ff <= 1'b0;
      else if (advance) s6_v_ff <= s5_v_ff;
      if (advance) begin
         s6_temp_ff <= s5_temp_ff;
         s6_v2_ff   <= s5_sq_ff * 64'(coef.p6) + (s5_v1p5_ff <<< 17)
                       + (64'(coef.p4) <<< ptc_pkg::P4Shift);
         s6_v1_ff   <= ((s5_sq_ff * 64'(coef.p3)) >>> 8) + (s5_v1p2_ff <<< 12);
         s6_adcp_ff <= s5_adcp_ff;
      end
   end

   // ------------------------------- stage 7: (2^47 + v1)*p1 >>> 33, numer base
   logic        s7_v_ff;
   logic signed [15:0] s7_temp_ff;
   logic signed [63:0] s7_den_ff, s7_num_ff;
   always_ff @(posedge clock) begin
      if (reset) s7_v_ff <= 1'b0;
      else if (advance) s7_v_ff <= s6_v_ff;
      if (advance) begin
         s7_temp_ff <= s6_temp_ff;
         s7_den_ff  <= (((64'sd1 <<< 47) + s6_v1_ff) * $signed({48'd0, coef.p1}))
                       >>> ptc_pkg::P1Shift;
         s7_num_ff  <= ((ptc_pkg::PresFull - 64'(s6_adcp_ff)) << 31) - s6_v2_ff;
      end
   end

   // ------------------------------- stage 8: numerator * 3125
   logic        s8_v_ff;
   logic signed [15:0] s8_temp_ff;
   logic signed [63:0] s8_den_ff, s8_num_ff;
   always_ff @(posedge clock) begin
      if (reset) s8_v_ff <= 1'b0;
      else if (advance) s8_v_ff <= s7_v_ff;
      if (advance) begin
         s8_temp_ff <= s7_temp_ff;
         s8_den_ff  <= s7_den_ff;
         s8_num_ff  <= s7_num_ff * ptc_pkg::PresScale;
      end
   end

   // ------------------------------- stage 9: magnitudes, sign, fault
   logic        s9_v_ff;
   logic [63:0] s9_mn_ff, s9_md_ff;
   ptc_pkg::div_side_type s9_side_ff;
   always_ff @(posedge clock) begin
      if (reset) s9_v_ff <= 1'b0;
      else if (advance) s9_v_ff <= s8_v_ff;
      if (advance) begin
         s9_mn_ff <= s8_num_ff[63] ? 64'(-s8_num_ff) : s8_num_ff;
         s9_md_ff <= s8_den_ff[63] ? 64'(-s8_den_ff) : s8_den_ff;
         s9_side_ff.temp  <= s8_temp_ff;
         s9_side_ff.p7    <= coef.p7;
         s9_side_ff.p8    <= coef.p8;
         s9_side_ff.p9    <= coef.p9;
         s9_side_ff.neg   <= s8_num_ff[63] ^ s8_den_ff[63];
         s9_side_ff.fault <= (s8_den_ff == 64'sd0);
      end
   end

   // ------------------------------- divider chain
   logic                  dv_v   [ptc_pkg::DivStages+1];
   logic [63:0]           dv_rem [ptc_pkg::DivStages+1];
   logic [63:0]           dv_quo [ptc_pkg::DivStages+1];
   logic [63:0]           dv_den [ptc_pkg::DivStages+1];
   ptc_pkg::div_side_type dv_side[ptc_pkg::DivStages+1];

   assign dv_v[0]    = s9_v_ff;
   assign dv_rem[0]  = '0;
   assign dv_quo[0]  = s9_mn_ff;
   assign dv_den[0]  = (s9_md_ff == 64'd0) ? 64'd1 : s9_md_ff;
   assign dv_side[0] = s9_side_ff;

   for (genvar g = 0; g < ptc_pkg::DivStages; g++) begin : g_div
      ptc_div_stage u_stage (
         .clock     (clock),
         .reset     (reset),
         .advance   (advance),
         .valid_in  (dv_v[g]),
         .rem_in    (dv_rem[g]),
         .quo_in    (dv_quo[g]),
         .den_in    (dv_den[g]),
         .side_in   (dv_side[g]),
         .valid_out (dv_v[g+1]),
         .rem_out   (dv_rem[g+1]),
         .quo_out   (dv_quo[g+1]),
         .den_out   (dv_den[g+1]),
         .side_out  (dv_side[g+1])
      );
   end

   // ------------------------------- back end: q, w1, w2, final
   logic        b1_v_ff;
   ptc_pkg::div_side_type b1_side_ff;
   logic signed [63:0] b1_p_ff, b1_q_ff;
   logic [63:0] qraw;
   assign qraw = dv_quo[ptc_pkg::DivStages];
   always_ff @(posedge clock) begin
      if (reset) b1_v_ff <= 1'b0;
      else if (advance) b1_v_ff <= dv_v[ptc_pkg::DivStages];
      if (advance) begin
         b1_side_ff <= dv_side[ptc_pkg::DivStages];
         b1_p_ff    <= dv_side[ptc_pkg::DivStages].neg ? 64'(-qraw) : qraw;
         b1_q_ff    <= $signed(dv_side[ptc_pkg::DivStages].neg ? 64'(-qraw) : qraw) >>> 13;
      end
   end

   logic        b2_v_ff;
   ptc_pkg::div_side_type b2_side_ff;
   logic signed [63:0] b2_p_ff, b2_p9q_ff, b2_q_ff, b2_w2_ff;
   always_ff @(posedge clock) begin
      if (reset) b2_v_ff <= 1'b0;
      else if (advance) b2_v_ff <= b1_v_ff;
      if (advance) begin
         b2_side_ff <= b1_side_ff;
         b2_p_ff    <= b1_p_ff;
         b2_q_ff    <= b1_q_ff;
         b2_p9q_ff  <= 64'(b1_side_ff.p9) * b1_q_ff;
         b2_w2_ff   <= (64'(b1_side_ff.p8) * b1_p_ff) >>> 19;
      end
   end

   // Form p9*q*q modulo 2^64 from 32-bit partial products; the high-by-high
   // term falls entirely above bit 63 and is dropped.
   logic        bm_v_ff;
   ptc_pkg::div_side_type bm_side_ff;
   logic signed [63:0] bm_p_ff, bm_w2_ff;
   logic [63:0] bm_ll_ff;
   logic [31:0] bm_lh_ff, bm_hl_ff;
   logic [63:0] ll_c;
   logic [31:0] lh_c, hl_c;
   assign ll_c = b2_p9q_ff[31:0] * b2_q_ff[31:0];
   assign lh_c = b2_p9q_ff[31:0] * b2_q_ff[63:32];
   assign hl_c = b2_p9q_ff[63:32] * b2_q_ff[31:0];
   always_ff @(posedge clock) begin
      if (reset) bm_v_ff <= 1'b0;
      else if (advance) bm_v_ff <= b2_v_ff;
      if (advance) begin
         bm_side_ff <= b2_side_ff;
         bm_p_ff    <= b2_p_ff;
         bm_w2_ff   <= b2_w2_ff;
         bm_ll_ff   <= ll_c;
         bm_lh_ff   <= lh_c;
         bm_hl_ff   <= hl_c;
      end
   end

   logic        b3_v_ff;
   ptc_pkg::div_side_type b3_side_ff;
   logic signed [63:0] b3_p_ff, b3_w1_ff, b3_w2_ff;
   always_ff @(posedge clock) begin
      if (reset) b3_v_ff <= 1'b0;
      else if (advance) b3_v_ff <= bm_v_ff;
      if (advance) begin
         b3_side_ff <= bm_side_ff;
         b3_p_ff    <= bm_p_ff;
         b3_w1_ff   <= $signed(bm_ll_ff + {bm_lh_ff + bm_hl_ff, 32'd0}) >>> 25;
         b3_w2_ff   <= bm_w2_ff;
      end
   end

   logic signed [63:0] pfinal;
   assign pfinal = ((b3_p_ff + b3_w1_ff + b3_w2_ff) >>> 8) + (64'(b3_side_ff.p7) <<< 4);

   // ------------------------------- output register
   ptc_pkg::rsp_type out_ff;
   always_ff @(posedge clock) begin
      if (reset) out_valid_ff <= 1'b0;
      else if (advance) out_valid_ff <= b3_v_ff;
      if (advance) begin
         out_ff.temperature_centi <= b3_side_ff.temp;
         out_ff.pressure_q24_8    <= b3_side_ff.fault ? '0 : pfinal[31:0];
         out_ff.divide_fault      <= b3_side_ff.fault;
      end
   end

   assign rsp.valid = out_valid_ff;
   assign rsp.data  = out_ff;
endmodule

// ----- hdl/ptc_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ptc_checker
// Port-level checks for the compensation block, bound to the top level.
// ----------------------------------------------------------------------------
module ptc_checker (
   input logic                 clock,
   input logic                 reset,
   input logic                 req_valid,
   input logic                 req_ready,
   input logic                 rsp_valid,
   input logic                 rsp_ready,
   input ptc_pkg::rsp_type     rsp_data
);
   // Hold a stalled result
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("result changed while stalled");

   // Faulted results carry zero pressure
   a_fault_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.divide_fault |-> rsp_data.pressure_q24_8 == '0)
      else $error("fault with nonzero pressure");

   // Input is refused only while a result is stalled
   a_ready: assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> rsp_valid && !rsp_ready)
      else $error("input refused without backpressure");

   // Nothing comes out right after reset
   a_reset: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("result valid after reset");
endmodule

bind pressure_temperature_compensation ptc_checker u_ptc_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req.valid),
   .req_ready (req.ready),
   .rsp_valid (rsp.valid),
   .rsp_ready (rsp.ready),
   .rsp_data  (rsp.data)
);

// ----- sim/tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the pressure/temperature compensation pipeline.
// ----------------------------------------------------------------------------
// A walk through a table of directed samples comes first, then phases of
// random samples under changing calibration sets. Each accepted sample not
// preset in the table is run through a local integer model of the compensation
// formulas. Each returned result is checked field by field against the oldest
// prediction. Both channels idle at random, and the response side holds off once
// for a long stretch so that the pipeline fills up and back-pressures its input.
module tb;

   localparam int HalfPeriod = 5;
   localparam int CycleLimit = 300000;
   localparam int DrainCycles = 60;
   localparam int HoldOffCycles = 300;
   localparam int RandPhases = 9;
   localparam int PhaseItems = 70;

   // calibration set kinds for random phases
   typedef enum int {
      SET_TYPICAL, SET_RANDOM, SET_ALL_ONES, SET_EDGES, SET_NO_DIVISOR, SET_QUIET
   } coef_set_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic csr_write = 1'b0;
   logic [ptc_pkg::CsrIdxWidth-1:0] csr_index = ptc_pkg::CSR_TEMP_COEF;
   logic [ptc_pkg::CsrWidth-1:0] csr_data = '0;

   ptc_stream_if #(.payload_type(ptc_pkg::req_type)) req_ch ();
   ptc_stream_if #(.payload_type(ptc_pkg::rsp_type)) rsp_ch ();

   pressure_temperature_compensation dut (
      .clock(clock),
      .reset(reset),
      .req(req_ch),
      .rsp(rsp_ch),
      .csr_write(csr_write),
      .csr_index(csr_index),
      .csr_data(csr_data)
   );

   always #HalfPeriod clock = ~clock;

   // shadow copy of the calibration registers
   logic [47:0] temp_coef_q = '0;
   logic [63:0] pres_low_q = '0;
   logic [63:0] pres_high_q = '0;
   logic [15:0] pres_nine_q = '0;

   ptc_pkg::rsp_type pending_results[$];
   int errors = 0;
   int cycles = 0;
   bit quiet = 1'b0;
   bit hold_kick = 1'b0;
   bit hold_done = 1'b0;
   int hold_left = 0;

   // fixed expectation riding along with the sample on the wire
   bit drv_exact = 1'b0;
   ptc_pkg::rsp_type drv_exp = '0;

   typedef struct {
      logic [19:0]      raw_t;
      logic [19:0]      raw_p;
      bit               typical;   // 0: reset calibration, 1: typical calibration
      bit               exact;
      ptc_pkg::rsp_type exp;
   } sample_row_type;

   // With all coefficients at reset the divisor is zero and fine temperature
   // is zero, so those rows carry the result directly.
   sample_row_type samples[] = '{
      '{20'h00000, 20'h00000, 1'b0, 1'b1, '{16'sd0, 32'd0, 1'b1}},
      '{20'hFFFFF, 20'hFFFFF, 1'b0, 1'b1, '{16'sd0, 32'd0, 1'b1}},
      '{20'hFFFFF, 20'h00000, 1'b0, 1'b1, '{16'sd0, 32'd0, 1'b1}},
      '{20'h00000, 20'hFFFFF, 1'b0, 1'b1, '{16'sd0, 32'd0, 1'b1}},
      '{20'h80000, 20'h55555, 1'b0, 1'b1, '{16'sd0, 32'd0, 1'b1}},
      '{20'h7EED0, 20'h65A40, 1'b1, 1'b0, '0},
      '{20'h80000, 20'h60000, 1'b1, 1'b0, '0},
      '{20'h00000, 20'h00000, 1'b1, 1'b0, '0},
      '{20'hFFFFF, 20'hFFFFF, 1'b1, 1'b0, '0},
      '{20'h00000, 20'hFFFFF, 1'b1, 1'b0, '0},
      '{20'hFFFFF, 20'h00000, 1'b1, 1'b0, '0},
      '{20'h6B600, 20'h5A000, 1'b1, 1'b0, '0},
      '{20'h90000, 20'h40000, 1'b1, 1'b0, '0},
      '{20'h55555, 20'hAAAAA, 1'b1, 1'b0, '0},
      '{20'hAAAAA, 20'h55555, 1'b1, 1'b0, '0},
      '{20'h00001, 20'h00001, 1'b1, 1'b0, '0},
      '{20'hFFFFE, 20'hFFFFE, 1'b1, 1'b0, '0}
   };

   function automatic ptc_pkg::rsp_type compensate(logic [19:0] raw_t, logic [19:0] raw_p);
      logic signed [31:0] t1, t2, t3, a, d, tv1, tv2, fine, tc;
      logic signed [63:0] p1, p2, p3, p4, p5, p6, p7, p8, p9;
      logic signed [63:0] f64, v1, v2, w, den, pr, p0, num, q, pq, w1, w2, fin;
      logic [63:0] mn, md, qu;
      ptc_pkg::rsp_type r;
      t1 = {16'b0, temp_coef_q[15:0]};
      t2 = {{16{temp_coef_q[31]}}, temp_coef_q[31:16]};
      t3 = {{16{temp_coef_q[47]}}, temp_coef_q[47:32]};
      p1 = {48'b0, pres_low_q[15:0]};
      p2 = {{48{pres_low_q[31]}}, pres_low_q[31:16]};
      p3 = {{48{pres_low_q[47]}}, pres_low_q[47:32]};
      p4 = {{48{pres_low_q[63]}}, pres_low_q[63:48]};
      p5 = {{48{pres_high_q[15]}}, pres_high_q[15:0]};
      p6 = {{48{pres_high_q[31]}}, pres_high_q[31:16]};
      p7 = {{48{pres_high_q[47]}}, pres_high_q[47:32]};
      p8 = {{48{pres_high_q[63]}}, pres_high_q[63:48]};
      p9 = {{48{pres_nine_q[15]}}, pres_nine_q};

      // temperature, wrapping 32-bit arithmetic
      a = {15'b0, raw_t[19:3]} - (t1 <<< 1);
      d = {16'b0, raw_t[19:4]} - t1;
      tv1 = (a * t2) >>> 11;
      tv2 = (((d * d) >>> 12) * t3) >>> 14;
      fine = tv1 + tv2;
      tc = (fine * 32'sd5 + 32'sd128) >>> 8;
      if (tc > 32'sd32767) r.temperature_centi = 16'sh7FFF;
      else if (tc < -32'sd32768) r.temperature_centi = 16'sh8000;
      else r.temperature_centi = tc[15:0];

      // pressure, wrapping 64-bit arithmetic
      f64 = fine;
      v1 = f64 - 64'sd128000;
      v2 = v1 * v1 * p6 + ((v1 * p5) <<< 17) + (p4 <<< 35);
      w = ((v1 * v1 * p3) >>> 8) + ((v1 * p2) <<< 12);
      den = (((64'sd1 <<< 47) + w) * p1) >>> 33;
      r.pressure_q24_8 = '0;
      r.divide_fault = 1'b0;
      if (den == 0) begin
         r.divide_fault = 1'b1;
      end else begin
         pr = {44'b0, raw_p};
         p0 = 64'sd1048576 - pr;
         num = ((p0 <<< 31) - v2) * 64'sd3125;
         // truncate toward zero; most negative over -1 wraps to itself
         mn = num[63] ? -num : num;
         md = den[63] ? -den : den;
         qu = mn / md;
         q = (num[63] ^ den[63]) ? -qu : qu;
         pq = q >>> 13;
         w1 = (p9 * pq * pq) >>> 25;
         w2 = (p8 * q) >>> 19;
         fin = ((q + w1 + w2) >>> 8) + (p7 <<< 4);
         r.pressure_q24_8 = fin[31:0];
      end
      return r;
   endfunction

   task automatic report_mismatch(string field, logic [63:0] got, logic [63:0] want);
      $display("mismatch %s: got %0h expected %0h at %0t", field, got, want, $realtime);
      errors++;
   endtask

   // Drain the pipeline, then load all four registers.
   task automatic load_coefficients(logic [63:0] tc, logic [63:0] pl, logic [63:0] ph,
                                    logic [63:0] p9);
      while (pending_results.size() != 0) @(posedge clock);
      repeat (DrainCycles) @(posedge clock);
      @(negedge clock);
      csr_write <= 1'b1;
      csr_index <= ptc_pkg::CSR_TEMP_COEF;
      csr_data <= tc;
      @(negedge clock);
      csr_index <= ptc_pkg::CSR_PRES_LOW;
      csr_data <= pl;
      @(negedge clock);
      csr_index <= ptc_pkg::CSR_PRES_HIGH;
      csr_data <= ph;
      @(negedge clock);
      csr_index <= ptc_pkg::CSR_PRES_NINE;
      csr_data <= p9;
      @(negedge clock);
      csr_write <= 1'b0;
      temp_coef_q = tc[47:0];
      pres_low_q = pl;
      pres_high_q = ph;
      pres_nine_q = p9[15:0];
   endtask

   // Offer one sample and hold it until the transfer; idle afterward at random.
   task automatic send_sample(logic [19:0] raw_t, logic [19:0] raw_p, bit exact,
                              ptc_pkg::rsp_type exp);
      @(negedge clock);
      req_ch.valid <= 1'b1;
      req_ch.data <= '{raw_temperature: raw_t, raw_pressure: raw_p};
      drv_exact <= exact;
      drv_exp <= exp;
      do @(posedge clock); while (!req_ch.ready);
      if (!quiet && $urandom_range(99) < 20) begin
         @(negedge clock);
         req_ch.valid <= 1'b0;
      end
   endtask

   function automatic logic [15:0] jitter(int base, int spread);
      return 16'(base + int'($urandom_range(2 * spread)) - spread);
   endfunction

   function automatic logic [19:0] random_raw();
      case ($urandom_range(9))
         0: return 20'h00000;
         1: return 20'hFFFFF;
         default: return 20'($urandom);
      endcase
   endfunction

   // Capture each accepted sample together with its prediction.
   always @(posedge clock) begin
      if (!reset && req_ch.valid && req_ch.ready) begin
         if (drv_exact) pending_results.push_back(drv_exp);
         else pending_results.push_back(
            compensate(req_ch.data.raw_temperature, req_ch.data.raw_pressure));
      end
   end

   // Check each transfer on the result side against the oldest prediction.
   always @(posedge clock) begin
      ptc_pkg::rsp_type want;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         if (pending_results.size() == 0) begin
            report_mismatch("unexpected result", 64'(rsp_ch.data), 64'd0);
         end else begin
            want = pending_results.pop_front();
            if (rsp_ch.data.temperature_centi !== want.temperature_centi)
               report_mismatch("temperature_centi", 64'(rsp_ch.data.temperature_centi),
                               64'(want.temperature_centi));
            if (rsp_ch.data.pressure_q24_8 !== want.pressure_q24_8)
               report_mismatch("pressure_q24_8", 64'(rsp_ch.data.pressure_q24_8),
                               64'(want.pressure_q24_8));
            if (rsp_ch.data.divide_fault !== want.divide_fault)
               report_mismatch("divide_fault", 64'(rsp_ch.data.divide_fault),
                               64'(want.divide_fault));
         end
      end
   end

   // Result-side ready: random idling, plus one long hold-off on request.
   always @(negedge clock) begin
      if (hold_kick && !hold_done) begin
         hold_done = 1'b1;
         hold_left = HoldOffCycles;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_ch.ready <= 1'b0;
      end else begin
         rsp_ch.ready <= quiet || ($urandom_range(99) >= 17);
      end
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles > CycleLimit) begin
         $display("*** FAILED ***");
         $finish;
      end
   end

   initial begin
      coef_set_type kind;
      logic [63:0] tc, pl, ph, p9;
      bit typical_loaded;
      req_ch.valid = 1'b0;
      req_ch.data = '0;
      rsp_ch.ready = 1'b0;
      typical_loaded = 1'b0;
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed table; typical calibration is loaded when its rows begin
      foreach (samples[i]) begin
         if (samples[i].typical && !typical_loaded) begin
            @(negedge clock);
            req_ch.valid <= 1'b0;
            load_coefficients({16'hFC18, 16'd26435, 16'd27504},
                              {16'd2855, 16'd3024, 16'hD643, 16'd36477},
                              {16'hC6F8, 16'd15500, 16'hFFF9, 16'd140},
                              64'd6000);
            typical_loaded = 1'b1;
         end
         send_sample(samples[i].raw_t, samples[i].raw_p, samples[i].exact, samples[i].exp);
      end

      for (int ph_i = 0; ph_i < RandPhases; ph_i++) begin
         kind = coef_set_type'(ph_i % 6);
         tc = {$urandom, $urandom};
         pl = {$urandom, $urandom};
         ph = {$urandom, $urandom};
         p9 = {$urandom, $urandom};
         case (kind)
            SET_TYPICAL, SET_QUIET: begin
               tc[47:0] = {jitter(-1000, 400), jitter(26435, 2000), jitter(27504, 2000)};
               pl = {jitter(2855, 500), jitter(3024, 500), jitter(-10685, 1000),
                     jitter(36477, 2000)};
               ph = {jitter(-14600, 1000), jitter(15500, 1000), jitter(-7, 4),
                     jitter(140, 40)};
               p9[15:0] = jitter(6000, 1000);
            end
            SET_ALL_ONES: begin
               tc = '1;
               pl = '1;
               ph = '1;
               p9 = '1;
            end
            SET_EDGES: begin
               tc = 64'h0000_8000_7FFF_FFFF;
               pl = 64'h8000_7FFF_8000_FFFF;
               ph = 64'h7FFF_8000_7FFF_8000;
               p9 = 64'hFFFF_FFFF_FFFF_8000;
            end
            SET_NO_DIVISOR: pl[15:0] = '0;
            default: ;
         endcase
         @(negedge clock);
         req_ch.valid <= 1'b0;
         load_coefficients(tc, pl, ph, p9);
         quiet = (kind == SET_QUIET);
         for (int k = 0; k < PhaseItems; k++) begin
            // long hold-off on the result side while samples keep coming
            if (ph_i == 1 && k == 10) hold_kick = 1'b1;
            send_sample(random_raw(), random_raw(), 1'b0, '0);
         end
         quiet = 1'b0;
      end

      @(negedge clock);
      req_ch.valid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (DrainCycles) @(posedge clock);
      if (errors == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule
